[hw/rtl/alm_pkg.sv]
// Shared types, codes and helpers of the array linked list manager.
package alm_pkg;

   // Operation codes carried in the mode field
   typedef enum logic [3:0] {
      MODE_INS_SLOT = 4'd0,
      MODE_INS_POS  = 4'd1,
      MODE_INS_HEAD = 4'd2,
      MODE_INS_TAIL = 4'd3,
      MODE_INS_KEY  = 4'd4,
      MODE_DEL_SLOT = 4'd5,
      MODE_DEL_POS  = 4'd6,
      MODE_DEL_KEY  = 4'd7,
      MODE_DEL_HEAD = 4'd8,
      MODE_DEL_TAIL = 4'd9,
      MODE_READ_POS = 4'd10,
      MODE_FIND     = 4'd11
   } mode_type;

   // Status codes of a result
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_ARG   = 3'd1;
   localparam logic [2:0] ST_NO_FREE   = 3'd2;
   localparam logic [2:0] ST_EMPTY     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   // Result fields except the count, which is sampled when the beat is loaded
   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  node_slot;
      logic [31:0] node_data;
      logic [9:0]  node_next;
      logic [9:0]  node_prev;
   } rsp_fields_type;

   function automatic rsp_fields_type error_result(input logic [2:0] status);
      rsp_fields_type r;
      r = '0;
      r.status = status;
      return r;
   endfunction

   // Narrow a slot index or count to the 10-bit result field
   function automatic logic [9:0] to_field10(input logic [15:0] v);
      return v[9:0];
   endfunction

endpackage

[hw/rtl/alm_if.sv]
// Request and response channel interfaces of the array linked list manager.
interface alm_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  mode;
   logic [9:0]  slot;
   logic [9:0]  position;
   logic [31:0] key;
   logic [31:0] value;

   modport source (output valid, mode, slot, position, key, value, input ready);
   modport sink   (input valid, mode, slot, position, key, value, output ready);
endinterface

interface alm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [9:0]  node_slot;
   logic [31:0] node_data;
   logic [9:0]  node_next;
   logic [9:0]  node_prev;
   logic [9:0]  count;

   modport source (output valid, status, node_slot, node_data, node_next, node_prev, count,
                   input ready);
   modport sink   (input valid, status, node_slot, node_data, node_next, node_prev, count,
                   output ready);
endinterface

[hw/rtl/array_linked_list_manager_top.sv]
// Top level of the array linked list manager: sequencer around the node store.
//
//   Channel   Dir   Handshake        Beat
//   req_bus   in    valid / ready    mode, slot, position, key, value
//   rsp_bus   out   valid / ready    status, node_slot, node_data, node_next, node_prev, count
//
// A request rejected at screening goes from the idle state straight to the done state.
// Others pass through the walk state, where each node that a position or key walk
// steps over is one read of the node RAM. Deletes relink through the act, DEL1,
// DEL2 and DEL3 states, inserts through the act, INS1 and INS2 states.
// After reset a clearing pass that writes every node once builds the free chain; no request
// is taken until it ends. A waiting response does not stop the next request; that
// request's result then waits in the done state until the output register frees.
module array_linked_list_manager_top
   import alm_pkg::*;
#(
   parameter int CAPACITY   = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   alm_req_if.sink    req_bus,
   alm_rsp_if.source  rsp_bus
);

   localparam int IW = $clog2(CAPACITY);
   localparam int RW = (IW > 10) ? IW : 10;
   localparam int WW = 1 + DATA_WIDTH + 2 * IW;

   typedef enum logic [9:0] {
      S_INIT = 10'b0000000001,
      S_IDLE = 10'b0000000010,
      S_WALK = 10'b0000000100,
      S_ACT  = 10'b0000001000,
      S_INS1 = 10'b0000010000,
      S_INS2 = 10'b0000100000,
      S_DEL1 = 10'b0001000000,
      S_DEL2 = 10'b0010000000,
      S_DEL3 = 10'b0100000000,
      S_DONE = 10'b1000000000
   } state_type;

   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in, val_ff, val_in;
   logic [IW-1:0]         cur_ff, cur_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic                  find_ff, find_in, back_ff, back_in;
   logic                  wu_ff, wu_in;
   logic [DATA_WIDTH-1:0] wd_ff, wd_in;
   logic [IW-1:0]         wp_ff, wp_in, wn_ff, wn_in;
   logic [IW-1:0]         newn_ff, newn_in;
   logic [IW-1:0]         free_top_ff, free_top_in;
   logic [IW-1:0]         count_ff, count_in;
   logic [IW-1:0]         init_ff, init_in;
   rsp_fields_type        res_ff, res_in;

   logic                  ram_we;
   logic [IW-1:0]         ram_waddr, ram_raddr;
   logic [WW-1:0]         ram_wdata, ram_rdata;

   logic                  r_used;
   logic [DATA_WIDTH-1:0] r_data;
   logic [IW-1:0]         r_prev, r_next;

   logic                  out_free, out_load;
   logic [16:0]           slot_w, pos_w, count_w, cap_w;
   logic [63:0]           key_ext, val_ext, wd_ext, valf_ext;
   logic [IW-1:0]         init_next;

   alm_ram #(.WIDTH(WW), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   alm_out u_out (
      .clock   (clock),
      .reset   (reset),
      .load    (out_load),
      .fields  (res_ff),
      .count   (to_field10(16'(count_ff))),
      .free    (out_free),
      .rsp_bus (rsp_bus)
   );

   // node word layout: {used, data, prev, next}
   assign r_next = ram_rdata[IW-1:0];
   assign r_prev = ram_rdata[2*IW-1:IW];
   assign r_data = ram_rdata[2*IW+DATA_WIDTH-1:2*IW];
   assign r_used = ram_rdata[WW-1];

   assign slot_w   = 17'(req_bus.slot);
   assign pos_w    = 17'(req_bus.position);
   assign count_w  = 17'(count_ff);
   assign cap_w    = 17'(CAPACITY);
   assign key_ext  = 64'(req_bus.key);
   assign val_ext  = 64'(req_bus.value);
   assign wd_ext   = 64'(wd_ff);
   assign valf_ext = 64'(val_ff);
   assign init_next = (init_ff == '0 || init_ff == IW'(CAPACITY - 1)) ? '0 : init_ff + 1'b1;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign out_load      = (state_ff == S_DONE) && out_free;

   // operation sequencer
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      key_in      = key_ff;
      val_in      = val_ff;
      cur_in      = cur_ff;
      rem_in      = rem_ff;
      find_in     = find_ff;
      back_in     = back_ff;
      wu_in       = wu_ff;
      wd_in       = wd_ff;
      wp_in       = wp_ff;
      wn_in       = wn_ff;
      newn_in     = newn_ff;
      free_top_in = free_top_ff;
      count_in    = count_ff;
      init_in     = init_ff;
      res_in      = res_ff;
      ram_we      = 1'b0;
      ram_waddr   = cur_ff;
      ram_wdata   = '0;
      ram_raddr   = '0;

      unique case (state_ff)
         // clearing pass: sentinel self-linked, free chain ascending
         S_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = init_ff;
            ram_wdata = {(init_ff == '0), {DATA_WIDTH{1'b0}}, {IW{1'b0}}, init_next};
            init_in   = init_ff + 1'b1;
            if (init_ff == IW'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end

         // take a request, screen arguments, start the walk
         S_IDLE: begin
            if (req_bus.valid) begin
               mode_in  = mode_type'(req_bus.mode);
               key_in   = key_ext[DATA_WIDTH-1:0];
               val_in   = val_ext[DATA_WIDTH-1:0];
               cur_in   = '0;
               rem_in   = '0;
               find_in  = 1'b0;
               back_in  = 1'b0;
               state_in = S_WALK;
               unique case (req_bus.mode) inside
                  MODE_INS_SLOT: begin
                     if (slot_w >= cap_w) begin
                        res_in   = error_result(ST_BAD_ARG);
                        state_in = S_DONE;
                     end else begin
                        cur_in    = slot_w[IW-1:0];
                        ram_raddr = slot_w[IW-1:0];
                     end
                  end
                  MODE_INS_POS, MODE_READ_POS: begin
                     if (pos_w > count_w) begin
                        res_in   = error_result(ST_BAD_ARG);
                        state_in = S_DONE;
                     end else begin
                        rem_in = RW'(req_bus.position);
                     end
                  end
                  MODE_INS_HEAD: begin
                  end
                  MODE_INS_TAIL: begin
                     rem_in  = RW'(1);
                     back_in = 1'b1;
                  end
                  MODE_INS_KEY, MODE_FIND: begin
                     find_in = 1'b1;
                     rem_in  = RW'(count_ff);
                  end
                  MODE_DEL_SLOT: begin
                     if (slot_w == '0 || slot_w >= cap_w) begin
                        res_in   = error_result(ST_BAD_ARG);
                        state_in = S_DONE;
                     end else if (count_ff == '0) begin
                        res_in   = error_result(ST_EMPTY);
                        state_in = S_DONE;
                     end else begin
                        cur_in    = slot_w[IW-1:0];
                        ram_raddr = slot_w[IW-1:0];
                     end
                  end
                  MODE_DEL_POS: begin
                     if (pos_w > count_w || pos_w == '0) begin
                        res_in   = error_result(ST_BAD_ARG);
                        state_in = S_DONE;
                     end else begin
                        rem_in = RW'(req_bus.position);
                     end
                  end
                  MODE_DEL_KEY: begin
                     if (count_ff == '0) begin
                        res_in   = error_result(ST_EMPTY);
                        state_in = S_DONE;
                     end else begin
                        find_in = 1'b1;
                        rem_in  = RW'(count_ff);
                     end
                  end
                  MODE_DEL_HEAD, MODE_DEL_TAIL: begin
                     if (count_ff == '0) begin
                        res_in   = error_result(ST_EMPTY);
                        state_in = S_DONE;
                     end else begin
                        rem_in  = RW'(1);
                        back_in = (req_bus.mode == MODE_DEL_TAIL);
                     end
                  end
                  default: begin
                     res_in   = error_result(ST_BAD_ARG);
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // one node per cycle: read data holds the word of cur
         S_WALK: begin
            if (find_ff && cur_ff != '0 && r_data == key_ff) begin
               state_in = S_ACT;
            end else if (rem_ff == '0) begin
               if (find_ff) begin
                  res_in   = error_result(ST_NOT_FOUND);
                  state_in = S_DONE;
               end else begin
                  state_in = S_ACT;
               end
            end else begin
               cur_in    = back_ff ? r_prev : r_next;
               ram_raddr = back_ff ? r_prev : r_next;
               rem_in    = rem_ff - 1'b1;
            end
            wu_in = r_used;
            wd_in = r_data;
            wp_in = r_prev;
            wn_in = r_next;
         end

         // act on the located node
         S_ACT: begin
            unique case (mode_ff) inside
               MODE_INS_SLOT, MODE_INS_POS, MODE_INS_HEAD, MODE_INS_TAIL,
               MODE_INS_KEY: begin
                  if (mode_ff == MODE_INS_SLOT && !wu_ff) begin
                     res_in   = error_result(ST_BAD_ARG);
                     state_in = S_DONE;
                  end else if (count_w >= cap_w - 17'd1) begin
                     res_in   = error_result(ST_NO_FREE);
                     state_in = S_DONE;
                  end else begin
                     // link after -> new node, fetch the new node's free link
                     ram_we    = 1'b1;
                     ram_waddr = cur_ff;
                     ram_wdata = {wu_ff, wd_ff, wp_ff, free_top_ff};
                     ram_raddr = free_top_ff;
                     newn_in   = free_top_ff;
                     state_in  = S_INS1;
                  end
               end
               MODE_DEL_SLOT, MODE_DEL_POS, MODE_DEL_KEY, MODE_DEL_HEAD,
               MODE_DEL_TAIL: begin
                  if (!wu_ff) begin
                     res_in   = error_result(ST_BAD_ARG);
                     state_in = S_DONE;
                  end else begin
                     // push the node on the free list, fetch its predecessor
                     ram_we      = 1'b1;
                     ram_waddr   = cur_ff;
                     ram_wdata   = {1'b0, {DATA_WIDTH{1'b0}}, {IW{1'b0}}, free_top_ff};
                     ram_raddr   = wp_ff;
                     free_top_in = cur_ff;
                     state_in    = S_DEL1;
                  end
               end
               default: begin
                  res_in.status    = ST_OK;
                  res_in.node_slot = to_field10(16'(cur_ff));
                  res_in.node_data = wd_ext[31:0];
                  res_in.node_next = to_field10(16'(wn_ff));
                  res_in.node_prev = to_field10(16'(wp_ff));
                  state_in         = S_DONE;
               end
            endcase
         end

         // write the new node, fetch its successor
         S_INS1: begin
            free_top_in = r_next;
            ram_we      = 1'b1;
            ram_waddr   = newn_ff;
            ram_wdata   = {1'b1, val_ff, cur_ff, wn_ff};
            ram_raddr   = wn_ff;
            state_in    = S_INS2;
         end

         // successor points back to the new node
         S_INS2: begin
            ram_we           = 1'b1;
            ram_waddr        = wn_ff;
            ram_wdata        = {r_used, r_data, newn_ff, r_next};
            count_in         = count_ff + 1'b1;
            res_in.status    = ST_OK;
            res_in.node_slot = to_field10(16'(newn_ff));
            res_in.node_data = valf_ext[31:0];
            res_in.node_next = to_field10(16'(wn_ff));
            res_in.node_prev = to_field10(16'(cur_ff));
            state_in         = S_DONE;
         end

         // predecessor skips the removed node
         S_DEL1: begin
            ram_we    = 1'b1;
            ram_waddr = wp_ff;
            ram_wdata = {r_used, r_data, r_prev, wn_ff};
            state_in  = S_DEL2;
         end

         // successor read after the predecessor write has landed
         S_DEL2: begin
            ram_raddr = wn_ff;
            state_in  = S_DEL3;
         end

         S_DEL3: begin
            ram_we           = 1'b1;
            ram_waddr        = wn_ff;
            ram_wdata        = {r_used, r_data, wp_ff, r_next};
            count_in         = count_ff - 1'b1;
            res_in.status    = ST_OK;
            res_in.node_slot = to_field10(16'(cur_ff));
            res_in.node_data = wd_ext[31:0];
            res_in.node_next = to_field10(16'(wn_ff));
            res_in.node_prev = to_field10(16'(wp_ff));
            state_in         = S_DONE;
         end

         // hand the result to the output register
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_INIT;
         init_ff     <= '0;
         free_top_ff <= IW'(1);
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         init_ff     <= init_in;
         free_top_ff <= free_top_in;
         count_ff    <= count_in;
      end
      mode_ff <= mode_in;
      key_ff  <= key_in;
      val_ff  <= val_in;
      cur_ff  <= cur_in;
      rem_ff  <= rem_in;
      find_ff <= find_in;
      back_ff <= back_in;
      wu_ff   <= wu_in;
      wd_ff   <= wd_in;
      wp_ff   <= wp_in;
      wn_ff   <= wn_in;
      newn_ff <= newn_in;
      res_ff  <= res_in;
   end

   // the list never holds more data nodes than the store minus the sentinel
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IW'(CAPACITY - 1))
      else $error("list count exceeds store size");

   // an insert only commits when a free node existed
   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS2 |-> count_w < cap_w - 17'd1)
      else $error("insert committed on a full store");

   // a delete only commits on a non-empty list
   a_del_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DEL3 |-> count_ff != '0)
      else $error("delete committed on an empty list");

   // no request is taken during the clearing pass
   a_init_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INIT |-> !req_bus.ready)
      else $error("request taken while clearing");

endmodule

[hw/rtl/alm_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module alm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[hw/rtl/alm_out.sv]
// Response output register: holds one result beat until the sink takes it.
module alm_out
   import alm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  rsp_fields_type  fields,
   input  logic [9:0]      count,
   output logic            free,
   alm_rsp_if.source       rsp_bus
);

   logic           valid_ff, valid_in;
   rsp_fields_type fields_ff;
   logic [9:0]     count_ff;

   // register is free when empty or being drained this cycle
   assign free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         fields_ff <= fields;
         count_ff  <= count;
      end
   end

   assign rsp_bus.valid     = valid_ff;
   assign rsp_bus.status    = fields_ff.status;
   assign rsp_bus.node_slot = fields_ff.node_slot;
   assign rsp_bus.node_data = fields_ff.node_data;
   assign rsp_bus.node_next = fields_ff.node_next;
   assign rsp_bus.node_prev = fields_ff.node_prev;
   assign rsp_bus.count     = count_ff;

endmodule

[tb/alm_tb_scoreboard.sv]
// Scoreboard for the array linked list manager: list predictor and result check.
`timescale 1ns / 1ps

// one result beat as seen on the response channel
typedef struct packed {
   logic [2:0]  status;
   logic [9:0]  node_slot;
   logic [31:0] node_data;
   logic [9:0]  node_next;
   logic [9:0]  node_prev;
   logic [9:0]  count;
} list_result_type;

class alm_list_scoreboard;
   localparam int CAP = 1024;

   // mirror of the node store
   logic [9:0]  nxt [CAP];
   logic [9:0]  prv [CAP];
   bit          used [CAP];
   logic [31:0] data [CAP];
   int unsigned free_head;
   int unsigned n_nodes;

   list_result_type pending_q[$];
   int unsigned     n_errors;
   int unsigned     n_checked;
   int unsigned     n_ok;

   function new();
      for (int i = 0; i < CAP; i++) begin
         nxt[i] = (i + 1 < CAP) ? 10'(i + 1) : 10'd0;
         prv[i] = '0;
         used[i] = 0;
         data[i] = '0;
      end
      nxt[0] = '0;
      used[0] = 1;
      free_head = 1;
      n_nodes = 0;
      n_errors = 0;
      n_checked = 0;
      n_ok = 0;
   endfunction

   function list_result_type make(logic [2:0] st, int unsigned s, logic [31:0] d,
                                  int unsigned nx, int unsigned pv);
      list_result_type r;
      r.status = st;
      r.node_slot = 10'(s);
      r.node_data = d;
      r.node_next = 10'(nx);
      r.node_prev = 10'(pv);
      r.count = 10'(n_nodes);
      return r;
   endfunction

   function int unsigned walk_to(int unsigned pos);
      int unsigned cur;
      cur = 0;
      for (int unsigned i = 0; i < pos; i++) cur = nxt[cur];
      return cur;
   endfunction

   function int unsigned search(logic [31:0] k);
      int unsigned cur;
      cur = 0;
      for (int unsigned i = 0; i < n_nodes; i++) begin
         cur = nxt[cur];
         if (cur != 0 && data[cur] == k) return cur;
      end
      return 0;
   endfunction

   function list_result_type link_after(int unsigned after, logic [31:0] v);
      int unsigned n, nx;
      if (n_nodes >= CAP - 1) return make(alm_pkg::ST_NO_FREE, 0, 0, 0, 0);
      n = free_head;
      free_head = nxt[n];
      nx = nxt[after];
      data[n] = v;
      used[n] = 1;
      nxt[n] = 10'(nx);
      prv[nx] = 10'(n);
      nxt[after] = 10'(n);
      prv[n] = 10'(after);
      n_nodes++;
      return make(alm_pkg::ST_OK, n, v, nx, after);
   endfunction

   function list_result_type unlink(int unsigned s);
      int unsigned pv, nx;
      logic [31:0] d;
      if (s == 0 || s >= CAP) return make(alm_pkg::ST_BAD_ARG, 0, 0, 0, 0);
      if (n_nodes == 0) return make(alm_pkg::ST_EMPTY, 0, 0, 0, 0);
      if (!used[s]) return make(alm_pkg::ST_BAD_ARG, 0, 0, 0, 0);
      pv = prv[s];
      nx = nxt[s];
      d = data[s];
      nxt[pv] = 10'(nx);
      prv[nx] = 10'(pv);
      data[s] = '0;
      used[s] = 0;
      prv[s] = '0;
      nxt[s] = 10'(free_head);
      free_head = s;
      n_nodes--;
      return make(alm_pkg::ST_OK, s, d, nx, pv);
   endfunction

   // note an accepted request beat and queue its expected result
   function void note_request(logic [3:0] mode, logic [9:0] slot, logic [9:0] pos,
                              logic [31:0] key, logic [31:0] value);
      list_result_type r;
      int unsigned s;
      case (mode)
         alm_pkg::MODE_INS_SLOT:
            r = used[slot] ? link_after(slot, value) : make(alm_pkg::ST_BAD_ARG, 0, 0, 0, 0);
         alm_pkg::MODE_INS_POS:
            r = (pos > n_nodes) ? make(alm_pkg::ST_BAD_ARG, 0, 0, 0, 0)
                                : link_after(walk_to(pos), value);
         alm_pkg::MODE_INS_HEAD: r = link_after(0, value);
         alm_pkg::MODE_INS_TAIL: r = link_after(prv[0], value);
         alm_pkg::MODE_INS_KEY: begin
            s = search(key);
            r = (s == 0) ? make(alm_pkg::ST_NOT_FOUND, 0, 0, 0, 0) : link_after(s, value);
         end
         alm_pkg::MODE_DEL_SLOT: r = unlink(slot);
         alm_pkg::MODE_DEL_POS:
            r = (pos > n_nodes || pos == 0) ? make(alm_pkg::ST_BAD_ARG, 0, 0, 0, 0)
                                            : unlink(walk_to(pos));
         alm_pkg::MODE_DEL_KEY: begin
            if (n_nodes == 0) r = make(alm_pkg::ST_EMPTY, 0, 0, 0, 0);
            else begin
               s = search(key);
               r = (s == 0) ? make(alm_pkg::ST_NOT_FOUND, 0, 0, 0, 0) : unlink(s);
            end
         end
         alm_pkg::MODE_DEL_HEAD:
            r = (n_nodes == 0) ? make(alm_pkg::ST_EMPTY, 0, 0, 0, 0) : unlink(nxt[0]);
         alm_pkg::MODE_DEL_TAIL:
            r = (n_nodes == 0) ? make(alm_pkg::ST_EMPTY, 0, 0, 0, 0) : unlink(prv[0]);
         alm_pkg::MODE_READ_POS: begin
            if (pos > n_nodes) r = make(alm_pkg::ST_BAD_ARG, 0, 0, 0, 0);
            else begin
               s = walk_to(pos);
               r = make(alm_pkg::ST_OK, s, data[s], nxt[s], prv[s]);
            end
         end
         alm_pkg::MODE_FIND: begin
            s = search(key);
            r = (s == 0) ? make(alm_pkg::ST_NOT_FOUND, 0, 0, 0, 0)
                         : make(alm_pkg::ST_OK, s, data[s], nxt[s], prv[s]);
         end
         default: r = make(alm_pkg::ST_BAD_ARG, 0, 0, 0, 0);
      endcase
      pending_q.push_back(r);
   endfunction

   // compare one accepted result beat with the oldest expectation
   function void check_result(list_result_type got);
      list_result_type exp_r;
      n_checked++;
      if (pending_q.size() == 0) begin
         $error("unexpected result beat, status %0d", got.status);
         n_errors++;
         return;
      end
      exp_r = pending_q.pop_front();
      if (got.status == alm_pkg::ST_OK) n_ok++;
      if (got.status !== exp_r.status) begin
         $error("status: expected %0d, got %0d", exp_r.status, got.status);
         n_errors++;
      end
      if (got.node_slot !== exp_r.node_slot) begin
         $error("node_slot: expected %0d, got %0d", exp_r.node_slot, got.node_slot);
         n_errors++;
      end
      if (got.node_data !== exp_r.node_data) begin
         $error("node_data: expected %h, got %h", exp_r.node_data, got.node_data);
         n_errors++;
      end
      if (got.node_next !== exp_r.node_next) begin
         $error("node_next: expected %0d, got %0d", exp_r.node_next, got.node_next);
         n_errors++;
      end
      if (got.node_prev !== exp_r.node_prev) begin
         $error("node_prev: expected %0d, got %0d", exp_r.node_prev, got.node_prev);
         n_errors++;
      end
      if (got.count !== exp_r.count) begin
         $error("count: expected %0d, got %0d", exp_r.count, got.count);
         n_errors++;
      end
   endfunction
endclass

[tb/array_linked_list_manager_top_tb.sv]
// Testbench top: drives list operations and checks every result beat.
`timescale 1ns / 1ps

module array_linked_list_manager_top_tb;
   import alm_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM = 900;
   localparam int N_TARGET = 1750;

   logic clock = 0;
   logic reset = 1;

   alm_req_if req_bus();
   alm_rsp_if rsp_bus();

   array_linked_list_manager_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   alm_list_scoreboard board = new();
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned idle_cycles;
   int unsigned n_sent;
   int unsigned n_full;
   logic [31:0] key_pool[$];

   // monitor both channels at the rising edge
   always @(posedge clock) begin
      list_result_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            board.note_request(req_bus.mode, req_bus.slot, req_bus.position,
                               req_bus.key, req_bus.value);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status = rsp_bus.status;
            got.node_slot = rsp_bus.node_slot;
            got.node_data = rsp_bus.node_data;
            got.node_next = rsp_bus.node_next;
            got.node_prev = rsp_bus.node_prev;
            got.count = rsp_bus.count;
            if (got.status == ST_NO_FREE) n_full++;
            board.check_result(got);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[array_linked_list_manager_top] ERROR");
         $finish;
      end
   end

   // receiver stalls at random
   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // send one request beat, with optional idle cycles before it
   task automatic send_req(logic [3:0] mode, logic [9:0] slot, logic [9:0] pos,
                           logic [31:0] key, logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= mode;
      req_bus.slot <= slot;
      req_bus.position <= pos;
      req_bus.key <= key;
      req_bus.value <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      n_sent++;
   endtask

   function automatic logic [31:0] pick_key();
      if (key_pool.size() > 0 && $urandom_range(3) != 0)
         return key_pool[$urandom_range(key_pool.size() - 1)];
      return $urandom();
   endfunction

   function automatic logic [31:0] fresh_value();
      logic [31:0] v;
      v = ($urandom_range(1) != 0) ? 32'($urandom_range(15)) : $urandom();
      if (key_pool.size() < 64) key_pool.push_back(v);
      else key_pool[$urandom_range(63)] = v;
      return v;
   endfunction

   // one random operation, biased toward useful arguments
   task automatic random_op(int unsigned grow_bias);
      logic [3:0] mode;
      logic [9:0] slot, pos;
      int unsigned cnt, r;
      cnt = board.n_nodes;
      r = $urandom_range(99);
      if (r < 2) mode = 4'($urandom_range(15, 12));
      else if (r < grow_bias) mode = mode_type'($urandom_range(4));
      else mode = 4'($urandom_range(11));
      slot = ($urandom_range(3) == 0) ? 10'($urandom()) : 10'($urandom_range(cnt + 2));
      pos = ($urandom_range(7) == 0) ? 10'($urandom()) : 10'($urandom_range(cnt + 1));
      send_req(mode, slot, pos, pick_key(), fresh_value());
   endtask

   // stop sending and wait for every result
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_INS_HEAD;
      req_bus.slot = '0;
      req_bus.position = '0;
      req_bus.key = '0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      idle_cycles = 0;
      n_sent = 0;
      n_full = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty-list cases, extremes, each operation
      send_req(MODE_DEL_HEAD, 0, 0, 0, 0);
      send_req(MODE_DEL_TAIL, 0, 0, 0, 0);
      send_req(MODE_DEL_KEY, 0, 0, 32'hFFFF_FFFF, 0);
      send_req(MODE_DEL_POS, 0, 1, 0, 0);
      send_req(MODE_DEL_SLOT, 10'd5, 0, 0, 0);
      send_req(MODE_READ_POS, 0, 0, 0, 0);
      send_req(MODE_FIND, 0, 0, 32'h0, 0);
      send_req(MODE_INS_SLOT, 10'd3, 0, 0, 32'h1);
      send_req(MODE_INS_HEAD, 0, 0, 0, 32'hFFFF_FFFF);
      send_req(MODE_INS_TAIL, 0, 0, 0, 32'h0);
      send_req(MODE_INS_POS, 0, 10'd2, 0, 32'hA5A5_5A5A);
      send_req(MODE_INS_POS, 0, 10'd1023, 0, 32'h1);
      send_req(MODE_INS_KEY, 0, 0, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
      send_req(MODE_INS_KEY, 0, 0, 32'h1234_5678, 32'h7);
      send_req(MODE_INS_SLOT, 0, 0, 0, 32'h0);
      send_req(MODE_INS_SLOT, 10'd1, 0, 0, 32'hFFFF_FFFF);
      send_req(MODE_FIND, 0, 0, 32'hFFFF_FFFF, 0);
      send_req(MODE_READ_POS, 0, 10'd3, 0, 0);
      send_req(MODE_READ_POS, 0, 10'd1023, 0, 0);
      send_req(MODE_DEL_SLOT, 10'd0, 0, 0, 0);
      send_req(MODE_DEL_SLOT, 10'd1023, 0, 0, 0);
      send_req(MODE_DEL_POS, 0, 0, 0, 0);
      send_req(MODE_DEL_KEY, 0, 0, 32'hFFFF_FFFF, 0);
      send_req(MODE_DEL_POS, 0, 10'd2, 0, 0);
      send_req(4'd15, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();

      // random phases with different idling on each side
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 71 : 0;
         recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 9 : 0;
         for (int i = 0; i < N_RANDOM / 3; i++) random_op(50);
         drain();
      end

      // fill the store once to reach the full case, then trim it from the tail
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (board.n_nodes < 1023) send_req(MODE_INS_HEAD, 0, 0, 0, $urandom());
      send_req(MODE_INS_TAIL, 0, 0, 0, 32'h1);
      send_req(MODE_INS_SLOT, 10'd0, 0, 0, 32'h2);
      send_req(MODE_READ_POS, 0, 10'd1023, 0, 0);
      send_req(MODE_DEL_POS, 0, 10'd1023, 0, 0);
      while (board.n_nodes > 0 && n_sent < N_TARGET) send_req(MODE_DEL_TAIL, 0, 0, 0, 0);
      drain();

      $display("Sent %0d request beats, checked %0d results (%0d ok, %0d store full).",
               n_sent, board.n_checked, board.n_ok, n_full);
      if (board.n_errors == 0 && board.pending_q.size() == 0)
         $display("[array_linked_list_manager_top] OK");
      else
         $display("[array_linked_list_manager_top] ERROR");
      $finish;
   end
endmodule
